// ===== rtl/dqb_pkg.sv =====
// ----------------------------------------------------------------------------
// dqb_pkg
// shared constants, transaction types and helpers of the dual quaternion blend
// ----------------------------------------------------------------------------
package dqb_pkg;

   localparam int REAL_FRAC_BITS   = 14;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int COMP_W     = 16;
   localparam int NUM_COMP   = 4;
   localparam int NUM_LANES  = 2 * NUM_COMP;
   localparam int WORD_W     = COMP_W * NUM_COMP;
   localparam int WEIGHT_W   = 17;
   localparam int BLEND_W    = COMP_W + 1;
   localparam int PROD_W     = 36;
   localparam int DOT_P_W    = 2 * COMP_W;
   localparam int DOT_W      = DOT_P_W + 2;
   localparam int SQR_W      = 2 * COMP_W;
   localparam int SUM_W      = SQR_W + 1;
   localparam int SQRT_SHIFT = 24;
   localparam int ROOT_W     = (SUM_W + SQRT_SHIFT + 1) / 2;
   localparam int SQ_W       = 2 * ROOT_W + 1;
   localparam int NORM_SHIFT = REAL_FRAC_BITS + 12;
   localparam int QUOT_BITS  = COMP_W - 1;
   localparam int MAG_W      = COMP_W + 1;
   localparam int DIV_W      = (NORM_SHIFT + MAG_W + 1 > ROOT_W + QUOT_BITS + 1) ?
                               NORM_SHIFT + MAG_W + 1 : ROOT_W + QUOT_BITS + 1;
   localparam int DIV_LAT    = QUOT_BITS + 1;
   localparam int DLY_LEN    = ROOT_W + DIV_LAT;
   localparam int PIPE_LAT   = 8 + DLY_LEN;
   localparam int COMP_MAX   = (1 << (COMP_W - 1)) - 1;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

   typedef logic signed [BLEND_W-1:0] blend_type;

   typedef struct packed {
      logic [WORD_W-1:0]   a_real;
      logic [WORD_W-1:0]   a_dual;
      logic [WORD_W-1:0]   b_real;
      logic [WORD_W-1:0]   b_dual;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] out_real;
      logic [WORD_W-1:0] out_dual;
      logic              zero_norm;
   } rsp_type;

   typedef struct packed {
      logic              t_zero;
      logic              t_one;
      logic [WORD_W-1:0] real_w;
      logic [WORD_W-1:0] dual_w;
   } byp_type;

   typedef struct packed {
      logic              use_alt;
      logic              zero_norm;
      logic [WORD_W-1:0] real_w;
      logic [WORD_W-1:0] dual_w;
   } alt_type;

   function automatic logic signed [COMP_W-1:0] get_comp(input logic [WORD_W-1:0] w,
                                                         input int k);
      return w[WORD_W-1-COMP_W*k -: COMP_W];
   endfunction

   function automatic logic [COMP_W-1:0] sat_comp(input blend_type v);
      if (v > $signed(BLEND_W'(COMP_MAX))) begin
         return COMP_W'(COMP_MAX);
      end else if (v < -$signed(BLEND_W'(COMP_MAX)) - 1) begin
         return COMP_W'(COMP_MAX) + COMP_W'(1);
      end
      return v[COMP_W-1:0];
   endfunction

endpackage

// ===== rtl/dual_quaternion_blend.sv =====
// ----------------------------------------------------------------------------
// dual_quaternion_blend
// linear blend of two dual quaternions, normalized by the blended real norm
// ----------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy stays low, so
// one blend enters per clock. The result appears on rsp_data with rsp_valid
// high for a single cycle, in input order; the receiver cannot stall and must
// capture it in that cycle. Each result passes through the 29-stage square
// root of the real norm followed by the 16-stage rounded divide that eight
// lanes run in parallel.
module dual_quaternion_blend (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dqb_pkg::req_type  req_data,
   output logic              rsp_valid,
   output dqb_pkg::rsp_type  rsp_data
);

   logic [6:0]                         vld_ff, vld_in;
   dqb_pkg::req_type                   req0_ff, req1_ff, req2_ff;
   logic signed [dqb_pkg::DOT_P_W-1:0] dot_ff [dqb_pkg::NUM_COMP];
   logic signed [dqb_pkg::DOT_W-1:0]   dot_sum;
   logic                               flip_ff;
   dqb_pkg::byp_type                   byp1_in, byp_ff [6];
   dqb_pkg::blend_type                 c4 [dqb_pkg::NUM_LANES];
   dqb_pkg::blend_type                 c5_ff [dqb_pkg::NUM_LANES];
   dqb_pkg::blend_type                 c6_ff [dqb_pkg::NUM_LANES];
   logic [dqb_pkg::SQR_W-1:0]          sq_ff [dqb_pkg::NUM_COMP];
   logic [dqb_pkg::SUM_W-1:0]          sum_ff;
   dqb_pkg::alt_type                   alt_in, alt_ff [dqb_pkg::DLY_LEN];
   logic [dqb_pkg::DLY_LEN-1:0]        vd_ff;
   dqb_pkg::blend_type                 cd_ff [dqb_pkg::ROOT_W][dqb_pkg::NUM_LANES];
   logic [dqb_pkg::ROOT_W-1:0]         root;
   logic [dqb_pkg::COMP_W-1:0]         quot [dqb_pkg::NUM_LANES];
   dqb_pkg::rsp_type                   rsp_in, rsp_ff;
   logic                               rsp_valid_ff;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[5:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         vd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         vd_ff        <= {vd_ff[dqb_pkg::DLY_LEN-2:0], vld_ff[6]};
         rsp_valid_ff <= vd_ff[dqb_pkg::DLY_LEN-1];
      end
   end

   // dot product of the real parts and bypass selection
   always_comb begin
      byp1_in.t_zero = req0_ff.weight == '0;
      byp1_in.t_one  = req0_ff.weight >= dqb_pkg::WEIGHT_ONE;
      byp1_in.real_w = byp1_in.t_zero ? req0_ff.a_real : req0_ff.b_real;
      byp1_in.dual_w = byp1_in.t_zero ? req0_ff.a_dual : req0_ff.b_dual;
      dot_sum = '0;
      for (int k = 0; k < dqb_pkg::NUM_COMP; k++) begin
         dot_sum = dot_sum + dqb_pkg::DOT_W'(dot_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      req0_ff   <= req_data;
      req1_ff   <= req0_ff;
      req2_ff   <= req1_ff;
      byp_ff[0] <= byp1_in;
      flip_ff   <= dot_sum[dqb_pkg::DOT_W-1];
      for (int k = 0; k < dqb_pkg::NUM_COMP; k++) begin
         dot_ff[k] <= dqb_pkg::DOT_P_W'(dqb_pkg::get_comp(req0_ff.a_real, k))
                      * dqb_pkg::DOT_P_W'(dqb_pkg::get_comp(req0_ff.b_real, k));
      end
      for (int s = 1; s < 6; s++) begin
         byp_ff[s] <= byp_ff[s-1];
      end
   end

   for (genvar k = 0; k < dqb_pkg::NUM_COMP; k++) begin : g_lane
      dqb_lane u_real (
         .clock  (clock),
         .a_comp (dqb_pkg::get_comp(req2_ff.a_real, k)),
         .b_comp (dqb_pkg::get_comp(req2_ff.b_real, k)),
         .flip   (flip_ff),
         .weight (req2_ff.weight),
         .blend  (c4[k])
      );
      dqb_lane u_dual (
         .clock  (clock),
         .a_comp (dqb_pkg::get_comp(req2_ff.a_dual, k)),
         .b_comp (dqb_pkg::get_comp(req2_ff.b_dual, k)),
         .flip   (flip_ff),
         .weight (req2_ff.weight),
         .blend  (c4[k + dqb_pkg::NUM_COMP])
      );
   end

   // merge: squared norm of the blended real part
   always_ff @(posedge clock) begin
      for (int j = 0; j < dqb_pkg::NUM_LANES; j++) begin
         c5_ff[j] <= c4[j];
         c6_ff[j] <= c5_ff[j];
      end
      for (int k = 0; k < dqb_pkg::NUM_COMP; k++) begin
         sq_ff[k] <= dqb_pkg::SQR_W'(c4[k]) * dqb_pkg::SQR_W'(c4[k]);
      end
      sum_ff <= dqb_pkg::SUM_W'(sq_ff[0]) + dqb_pkg::SUM_W'(sq_ff[1])
              + dqb_pkg::SUM_W'(sq_ff[2]) + dqb_pkg::SUM_W'(sq_ff[3]);
   end

   always_comb begin
      alt_in.zero_norm = (sum_ff == '0) && !byp_ff[5].t_zero && !byp_ff[5].t_one;
      alt_in.use_alt   = (sum_ff == '0) || byp_ff[5].t_zero || byp_ff[5].t_one;
      if (byp_ff[5].t_zero || byp_ff[5].t_one) begin
         alt_in.real_w = byp_ff[5].real_w;
         alt_in.dual_w = byp_ff[5].dual_w;
      end else begin
         for (int k = 0; k < dqb_pkg::NUM_COMP; k++) begin
            alt_in.real_w[dqb_pkg::WORD_W-1-dqb_pkg::COMP_W*k -: dqb_pkg::COMP_W] =
               dqb_pkg::sat_comp(c6_ff[k]);
            alt_in.dual_w[dqb_pkg::WORD_W-1-dqb_pkg::COMP_W*k -: dqb_pkg::COMP_W] =
               dqb_pkg::sat_comp(c6_ff[k + dqb_pkg::NUM_COMP]);
         end
      end
   end

   always_ff @(posedge clock) begin
      alt_ff[0] <= alt_in;
      for (int s = 1; s < dqb_pkg::DLY_LEN; s++) begin
         alt_ff[s] <= alt_ff[s-1];
      end
      for (int j = 0; j < dqb_pkg::NUM_LANES; j++) begin
         cd_ff[0][j] <= c6_ff[j];
         for (int s = 1; s < dqb_pkg::ROOT_W; s++) begin
            cd_ff[s][j] <= cd_ff[s-1][j];
         end
      end
   end

   dqb_sqrt u_sqrt (
      .clock    (clock),
      .radicand (dqb_pkg::SQ_W'(sum_ff) << dqb_pkg::SQRT_SHIFT),
      .root     (root)
   );

   for (genvar j = 0; j < dqb_pkg::NUM_LANES; j++) begin : g_div
      dqb_div u_div (
         .clock (clock),
         .comp  (cd_ff[dqb_pkg::ROOT_W-1][j]),
         .norm  (root),
         .quot  (quot[j])
      );
   end

   always_comb begin
      rsp_in.zero_norm = alt_ff[dqb_pkg::DLY_LEN-1].zero_norm;
      if (alt_ff[dqb_pkg::DLY_LEN-1].use_alt) begin
         rsp_in.out_real = alt_ff[dqb_pkg::DLY_LEN-1].real_w;
         rsp_in.out_dual = alt_ff[dqb_pkg::DLY_LEN-1].dual_w;
      end else begin
         for (int k = 0; k < dqb_pkg::NUM_COMP; k++) begin
            rsp_in.out_real[dqb_pkg::WORD_W-1-dqb_pkg::COMP_W*k -: dqb_pkg::COMP_W] = quot[k];
            rsp_in.out_dual[dqb_pkg::WORD_W-1-dqb_pkg::COMP_W*k -: dqb_pkg::COMP_W] =
               quot[k + dqb_pkg::NUM_COMP];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(dqb_pkg::PIPE_LAT) rsp_valid)
      else $error("accepted transaction produced no result");

   a_zero_norm_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_norm |-> rsp_data.out_real == '0)
      else $error("zero norm flagged with nonzero real part");

   a_weight_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(start, dqb_pkg::PIPE_LAT)
      && $past(req_data.weight, dqb_pkg::PIPE_LAT) == '0
      |-> rsp_data.out_real == $past(req_data.a_real, dqb_pkg::PIPE_LAT))
      else $error("zero weight did not return first operand");

endmodule

// ===== rtl/dqb_lane.sv =====
// ----------------------------------------------------------------------------
// dqb_lane
// one blend lane: weighted sum of two components, rounded back to input format
// ----------------------------------------------------------------------------
module dqb_lane (
   input  logic                                 clock,
   input  logic signed [dqb_pkg::COMP_W-1:0]    a_comp,
   input  logic signed [dqb_pkg::COMP_W-1:0]    b_comp,
   input  logic                                 flip,
   input  logic [dqb_pkg::WEIGHT_W-1:0]         weight,
   output dqb_pkg::blend_type                   blend
);

   logic signed [dqb_pkg::BLEND_W-1:0]  b_adj;
   logic signed [dqb_pkg::WEIGHT_W:0]   w_b;
   logic signed [dqb_pkg::WEIGHT_W:0]   w_a;
   logic signed [dqb_pkg::PROD_W-1:0]   pa_in, pa_ff, pb_in, pb_ff, sum;
   logic [dqb_pkg::PROD_W-1:0]          mag, rnd;
   dqb_pkg::blend_type                  blend_in, blend_ff;

   always_comb begin
      b_adj    = flip ? -dqb_pkg::BLEND_W'(b_comp) : dqb_pkg::BLEND_W'(b_comp);
      w_b      = $signed({1'b0, weight});
      w_a      = $signed({1'b0, dqb_pkg::WEIGHT_ONE}) - $signed({1'b0, weight});
      pa_in    = dqb_pkg::PROD_W'(a_comp) * dqb_pkg::PROD_W'(w_a);
      pb_in    = dqb_pkg::PROD_W'(b_adj) * dqb_pkg::PROD_W'(w_b);
      sum      = pa_ff + pb_ff;
      mag      = sum[dqb_pkg::PROD_W-1] ? unsigned'(-sum) : unsigned'(sum);
      rnd      = (mag + (dqb_pkg::PROD_W'(1) << (dqb_pkg::WEIGHT_FRAC_BITS - 1)))
                 >> dqb_pkg::WEIGHT_FRAC_BITS;
      blend_in = sum[dqb_pkg::PROD_W-1] ? -dqb_pkg::BLEND_W'(rnd) : dqb_pkg::BLEND_W'(rnd);
   end

   always_ff @(posedge clock) begin
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      blend_ff <= blend_in;
   end

   assign blend = blend_ff;

endmodule

// ===== rtl/dqb_sqrt.sv =====
// ----------------------------------------------------------------------------
// dqb_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module dqb_sqrt (
   input  logic                          clock,
   input  logic [dqb_pkg::SQ_W-1:0]      radicand,
   output logic [dqb_pkg::ROOT_W-1:0]    root
);

   logic [dqb_pkg::SQ_W-1:0]   rem_ff  [dqb_pkg::ROOT_W];
   logic [dqb_pkg::ROOT_W-1:0] root_ff [dqb_pkg::ROOT_W];

   for (genvar j = 0; j < dqb_pkg::ROOT_W; j++) begin : g_step
      localparam int BIT = dqb_pkg::ROOT_W - 1 - j;
      logic [dqb_pkg::SQ_W-1:0]   rem_prev, trial, rem_in;
      logic [dqb_pkg::ROOT_W-1:0] root_prev, root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
      end

      always_comb begin
         trial = ({{(dqb_pkg::SQ_W - dqb_pkg::ROOT_W){1'b0}}, root_prev} << (BIT + 1))
                 + (dqb_pkg::SQ_W'(1) << (2 * BIT));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (dqb_pkg::ROOT_W'(1) << BIT);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
      end
   end

   assign root = root_ff[dqb_pkg::ROOT_W-1];

endmodule

// ===== rtl/dqb_div.sv =====
// ----------------------------------------------------------------------------
// dqb_div
// pipelined rounded divide of one component by the norm, saturated result
// ----------------------------------------------------------------------------
module dqb_div (
   input  logic                          clock,
   input  dqb_pkg::blend_type            comp,
   input  logic [dqb_pkg::ROOT_W-1:0]    norm,
   output logic [dqb_pkg::COMP_W-1:0]    quot
);

   logic [dqb_pkg::DIV_W-1:0]     r_ff   [dqb_pkg::DIV_LAT];
   logic [dqb_pkg::ROOT_W-1:0]    d_ff   [dqb_pkg::DIV_LAT];
   logic [dqb_pkg::QUOT_BITS-1:0] q_ff   [dqb_pkg::DIV_LAT];
   logic                          neg_ff [dqb_pkg::DIV_LAT];
   logic                          ovf_ff [dqb_pkg::DIV_LAT];

   logic [dqb_pkg::MAG_W-1:0] mag, qmag, qneg;
   logic [dqb_pkg::DIV_W-1:0] numer, limit;

   always_comb begin
      mag   = comp[dqb_pkg::BLEND_W-1] ? unsigned'(-comp) : unsigned'(comp);
      numer = (dqb_pkg::DIV_W'(mag) << dqb_pkg::NORM_SHIFT) + dqb_pkg::DIV_W'(norm >> 1);
      limit = dqb_pkg::DIV_W'(norm) << dqb_pkg::QUOT_BITS;
   end

   always_ff @(posedge clock) begin
      r_ff[0]   <= numer;
      d_ff[0]   <= norm;
      q_ff[0]   <= '0;
      neg_ff[0] <= comp[dqb_pkg::BLEND_W-1];
      ovf_ff[0] <= numer >= limit;
   end

   for (genvar j = 1; j < dqb_pkg::DIV_LAT; j++) begin : g_step
      localparam int BIT = dqb_pkg::QUOT_BITS - j;
      logic [dqb_pkg::DIV_W-1:0]     sub, r_in;
      logic [dqb_pkg::QUOT_BITS-1:0] q_in;

      always_comb begin
         sub = dqb_pkg::DIV_W'(d_ff[j-1]) << BIT;
         if (r_ff[j-1] >= sub) begin
            r_in = r_ff[j-1] - sub;
            q_in = q_ff[j-1] | (dqb_pkg::QUOT_BITS'(1) << BIT);
         end else begin
            r_in = r_ff[j-1];
            q_in = q_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[j]   <= r_in;
         d_ff[j]   <= d_ff[j-1];
         q_ff[j]   <= q_in;
         neg_ff[j] <= neg_ff[j-1];
         ovf_ff[j] <= ovf_ff[j-1];
      end
   end

   always_comb begin
      qmag = ovf_ff[dqb_pkg::DIV_LAT-1] ? (dqb_pkg::MAG_W'(1) << dqb_pkg::QUOT_BITS)
                                        : dqb_pkg::MAG_W'(q_ff[dqb_pkg::DIV_LAT-1]);
      qneg = -qmag;
      if (neg_ff[dqb_pkg::DIV_LAT-1]) begin
         quot = qneg[dqb_pkg::COMP_W-1:0];
      end else if (qmag > dqb_pkg::MAG_W'(dqb_pkg::COMP_MAX)) begin
         quot = dqb_pkg::COMP_W'(dqb_pkg::COMP_MAX);
      end else begin
         quot = qmag[dqb_pkg::COMP_W-1:0];
      end
   end

endmodule
